@@ rtl/core/mdx_pkg.sv @@
// Opcode and function codes, result record and decode/execute function for the MIPS stage.
`timescale 1ns / 1ps
`default_nettype none

package mdx_pkg;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_JAL   = 6'h03;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_BNE   = 6'h05;
    localparam logic [5:0] OP_ADDI  = 6'h08;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_SLTI  = 6'h0a;
    localparam logic [5:0] OP_SLTIU = 6'h0b;
    localparam logic [5:0] OP_ANDI  = 6'h0c;
    localparam logic [5:0] OP_ORI   = 6'h0d;
    localparam logic [5:0] OP_LUI   = 6'h0f;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2b;

    localparam logic [5:0] FN_SLL  = 6'h00;
    localparam logic [5:0] FN_SRL  = 6'h02;
    localparam logic [5:0] FN_JR   = 6'h08;
    localparam logic [5:0] FN_ADD  = 6'h20;
    localparam logic [5:0] FN_ADDU = 6'h21;
    localparam logic [5:0] FN_SUB  = 6'h22;
    localparam logic [5:0] FN_SUBU = 6'h23;
    localparam logic [5:0] FN_AND  = 6'h24;
    localparam logic [5:0] FN_OR   = 6'h25;
    localparam logic [5:0] FN_NOR  = 6'h27;
    localparam logic [5:0] FN_SLT  = 6'h2a;
    localparam logic [5:0] FN_SLTU = 6'h2b;

    localparam logic [4:0] LINK_REG = 5'd31;

    typedef struct packed {
        logic [31:0] result;
        logic [4:0]  dest_reg;
        logic        reg_write;
        logic        mem_read;
        logic        mem_write;
        logic [31:0] store_data;
        logic        is_branch;
        logic        branch_taken;
        logic        redirect;
        logic [31:0] redirect_target;
    } exec_t;

    function automatic exec_t decode_execute(
        input logic [31:0] ins,
        input logic [31:0] rsv,
        input logic [31:0] rtv,
        input logic [31:0] addr
    );
        exec_t       r;
        logic [5:0]  op;
        logic [5:0]  fn;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [4:0]  sh;
        logic [15:0] imm;
        logic [31:0] simm;
        logic [31:0] zimm;
        logic [31:0] pc4;
        logic [31:0] eff_addr;
        logic        eq;
        op       = ins[31:26];
        fn       = ins[5:0];
        rt       = ins[20:16];
        rd       = ins[15:11];
        sh       = ins[10:6];
        imm      = ins[15:0];
        simm     = {{16{imm[15]}}, imm};
        zimm     = {16'h0000, imm};
        pc4      = addr + 32'd4;
        eff_addr = rsv + simm;
        eq       = (rsv == rtv);
        r        = '0;
        case (op)
            OP_RTYPE:
            begin
                r.reg_write = 1'b1;
                r.dest_reg  = rd;
                case (fn)
                    FN_SLL:          r.result = rtv << sh;
                    FN_SRL:          r.result = rtv >> sh;
                    FN_ADD, FN_ADDU: r.result = rsv + rtv;
                    FN_SUB, FN_SUBU: r.result = rsv - rtv;
                    FN_AND:          r.result = rsv & rtv;
                    FN_OR:           r.result = rsv | rtv;
                    FN_NOR:          r.result = ~(rsv | rtv);
                    FN_SLT:          r.result = {31'd0, $signed(rsv) < $signed(rtv)};
                    FN_SLTU:         r.result = {31'd0, rsv < rtv};
                    FN_JR:
                    begin
                        r.reg_write       = 1'b0;
                        r.dest_reg        = '0;
                        r.redirect        = 1'b1;
                        r.redirect_target = rsv;
                    end
                    default:
                    begin
                        r.reg_write = 1'b0;
                        r.dest_reg  = '0;
                    end
                endcase
            end
            OP_ADDI, OP_ADDIU:
            begin
                r.reg_write = 1'b1;
                r.dest_reg  = rt;
                r.result    = eff_addr;
            end
            OP_SLTI:
            begin
                r.reg_write = 1'b1;
                r.dest_reg  = rt;
                r.result    = {31'd0, $signed(rsv) < $signed(simm)};
            end
            OP_SLTIU:
            begin
                r.reg_write = 1'b1;
                r.dest_reg  = rt;
                r.result    = {31'd0, rsv < simm};
            end
            OP_ANDI:
            begin
                r.reg_write = 1'b1;
                r.dest_reg  = rt;
                r.result    = rsv & zimm;
            end
            OP_ORI:
            begin
                r.reg_write = 1'b1;
                r.dest_reg  = rt;
                r.result    = rsv | zimm;
            end
            OP_LUI:
            begin
                r.reg_write = 1'b1;
                r.dest_reg  = rt;
                r.result    = {imm, 16'h0000};
            end
            OP_LW:
            begin
                r.reg_write = 1'b1;
                r.dest_reg  = rt;
                r.mem_read  = 1'b1;
                r.result    = eff_addr;
            end
            OP_SW:
            begin
                r.mem_write  = 1'b1;
                r.result     = eff_addr;
                r.store_data = rtv;
            end
            OP_BEQ, OP_BNE:
            begin
                r.is_branch    = 1'b1;
                r.branch_taken = (op == OP_BEQ) ? eq : !eq;
                if (r.branch_taken)
                begin
                    r.redirect        = 1'b1;
                    r.redirect_target = pc4 + {simm[29:0], 2'b00};
                end
            end
            OP_J, OP_JAL:
            begin
                r.redirect        = 1'b1;
                r.redirect_target = {pc4[31:28], ins[25:0], 2'b00};
                if (op == OP_JAL)
                begin
                    r.reg_write = 1'b1;
                    r.dest_reg  = LINK_REG;
                    r.result    = addr + 32'd8;
                end
            end
            default:
            begin
                r = '0;
            end
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/mips_decode_execute_top.sv @@
// MIPS decode and execute stage: input register, decode/ALU logic, result register.
//
// Input channel: in_valid/in_ready carry one request of instruction, rs_value,
// rt_value and inst_address. Output channel: out_valid/out_ready carry one
// result with the ALU/link/address value, destination and write enable,
// memory flags with store data, branch status and redirect target.
// Each request gives exactly one result, in order.
// The input register loads at the accepting edge, and the result register loads
// from it once it is empty or being drained; out_valid rises with it (the decode and ALU
// logic sits between the two registers).
// Throughput: one request per cycle while out_ready stays high.
// Reset clears both valid flags; payload registers are not reset.
// When the receiver stalls, the result register holds; one more request is
// still taken into the input register, after which in_ready drops until the
// result register drains.
`timescale 1ns / 1ps
`default_nettype none

module mips_decode_execute_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] instruction,
    input  wire logic [31:0] rs_value,
    input  wire logic [31:0] rt_value,
    input  wire logic [31:0] inst_address,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      result,
    output logic [4:0]       dest_reg,
    output logic             reg_write,
    output logic             mem_read,
    output logic             mem_write,
    output logic [31:0]      store_data,
    output logic             is_branch,
    output logic             branch_taken,
    output logic             redirect,
    output logic [31:0]      redirect_target
);
    import mdx_pkg::*;

    logic        s1_valid_reg;
    logic [31:0] ins_reg;
    logic [31:0] rsv_reg;
    logic [31:0] rtv_reg;
    logic [31:0] addr_reg;
    logic        out_valid_reg;
    exec_t       exec_reg;
    exec_t       exec_next;
    logic        out_load;
    logic        s1_advance;
    logic        in_accept;

    assign out_load   = !out_valid_reg || out_ready;
    assign s1_advance = s1_valid_reg && out_load;
    assign in_ready   = !s1_valid_reg || out_load;
    assign in_accept  = in_valid && in_ready;
    assign exec_next  = decode_execute(ins_reg, rsv_reg, rtv_reg, addr_reg);

    // advance the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            ins_reg  <= instruction;
            rsv_reg  <= rs_value;
            rtv_reg  <= rt_value;
            addr_reg <= inst_address;
        end
    end

    // load the result register, hold it while the receiver stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            exec_reg <= exec_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign result          = exec_reg.result;
    assign dest_reg        = exec_reg.dest_reg;
    assign reg_write       = exec_reg.reg_write;
    assign mem_read        = exec_reg.mem_read;
    assign mem_write       = exec_reg.mem_write;
    assign store_data      = exec_reg.store_data;
    assign is_branch       = exec_reg.is_branch;
    assign branch_taken    = exec_reg.branch_taken;
    assign redirect        = exec_reg.redirect;
    assign redirect_target = exec_reg.redirect_target;

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> s1_valid_reg)
        else $error("accepted request did not reach the input register");

    a_s1_moves_out: assert property (@(posedge clk) disable iff (!rst_n)
        s1_advance |=> out_valid_reg)
        else $error("advanced request did not reach the result register");

    a_dest_zero_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !exec_reg.reg_write |-> exec_reg.dest_reg == 5'd0)
        else $error("destination set without a register write");

    a_mem_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(exec_reg.mem_read && exec_reg.mem_write))
        else $error("load and store flagged together");

    a_branch_redirect: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && exec_reg.is_branch |-> exec_reg.redirect == exec_reg.branch_taken)
        else $error("branch redirect does not follow the taken flag");

endmodule

`default_nettype wire
